>>> rtl/dfiir_pkg.sv
`timescale 1ns / 1ps

package dfiir_pkg;

	localparam int SAMPLE_W    = 24;
	localparam int GAIN_W      = 24;
	localparam int PROD_W      = SAMPLE_W + GAIN_W;
	// Six products of up to 2^46 each plus the rounding half fit in 52 bits.
	localparam int ACC_W       = 52;
	localparam int FRAC_SHIFT  = 16;
	localparam int Q_W         = ACC_W - FRAC_SHIFT;
	localparam int NUM_FF_GAIN = 4;
	localparam int NUM_FB_GAIN = 2;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 24;
	localparam int FF_TAPS_W   = 3;
	localparam int FB_TAPS_W   = 2;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [GAIN_W-1:0]   gain_t;
	typedef logic signed [PROD_W-1:0]   prod_t;
	typedef logic signed [ACC_W-1:0]    acc_t;

	localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
	localparam acc_t    ROUND_HALF = acc_t'(1) <<< (FRAC_SHIFT - 1);
	localparam gain_t   GAIN_ONE   = gain_t'(1) <<< FRAC_SHIFT;

	localparam logic REQ_FILTER = 1'b0;
	localparam logic REQ_CLEAR  = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FF_GAIN_0    = 3'd0,
		CFG_FF_GAIN_1    = 3'd1,
		CFG_FF_GAIN_2    = 3'd2,
		CFG_FF_GAIN_3    = 3'd3,
		CFG_FB_GAIN_0    = 3'd4,
		CFG_FB_GAIN_1    = 3'd5,
		CFG_FF_TAPS_USED = 3'd6,
		CFG_FB_TAPS_USED = 3'd7
	} cfg_idx_e;

	typedef struct packed {
		gain_t [NUM_FF_GAIN-1:0] ff_gain;
		gain_t [NUM_FB_GAIN-1:0] fb_gain;
		logic [FF_TAPS_W-1:0]    ff_taps_used;
		logic [FB_TAPS_W-1:0]    fb_taps_used;
	} cfg_t;

	// Feed-forward partial result handed to the feedback stage.
	typedef struct packed {
		logic clr;
		acc_t sum;
	} ff_sum_t;

endpackage

>>> rtl/dfiir_in_if.sv
`timescale 1ns / 1ps

interface dfiir_in_if;
	import dfiir_pkg::*;

	logic    valid;
	logic    ready;
	logic    req_type;
	sample_t sample_in;

	modport source (output valid, output req_type, output sample_in, input ready);
	modport sink (input valid, input req_type, input sample_in, output ready);
endinterface

>>> rtl/dfiir_out_if.sv
`timescale 1ns / 1ps

interface dfiir_out_if;
	import dfiir_pkg::*;

	logic    valid;
	logic    ready;
	sample_t filtered_out;
	logic    saturated;

	modport source (output valid, output filtered_out, output saturated, input ready);
	modport sink (input valid, input filtered_out, input saturated, output ready);
endinterface

>>> rtl/dfiir_cfg_regs.sv
`timescale 1ns / 1ps

module dfiir_cfg_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [dfiir_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [dfiir_pkg::CFG_DATA_W-1:0]  cfg_data,
	output dfiir_pkg::cfg_t                   cfg
);
	import dfiir_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ff_gain[0]   <= GAIN_ONE;
			for (int i = 1; i < NUM_FF_GAIN; i++) cfg_q.ff_gain[i] <= '0;
			cfg_q.fb_gain      <= '0;
			cfg_q.ff_taps_used <= FF_TAPS_W'(1);
			cfg_q.fb_taps_used <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx_e'(cfg_idx))
				CFG_FF_GAIN_0:    cfg_q.ff_gain[0]   <= gain_t'(cfg_data);
				CFG_FF_GAIN_1:    cfg_q.ff_gain[1]   <= gain_t'(cfg_data);
				CFG_FF_GAIN_2:    cfg_q.ff_gain[2]   <= gain_t'(cfg_data);
				CFG_FF_GAIN_3:    cfg_q.ff_gain[3]   <= gain_t'(cfg_data);
				CFG_FB_GAIN_0:    cfg_q.fb_gain[0]   <= gain_t'(cfg_data);
				CFG_FB_GAIN_1:    cfg_q.fb_gain[1]   <= gain_t'(cfg_data);
				CFG_FF_TAPS_USED: cfg_q.ff_taps_used <= cfg_data[FF_TAPS_W-1:0];
				CFG_FB_TAPS_USED: cfg_q.fb_taps_used <= cfg_data[FB_TAPS_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule

>>> rtl/dfiir_ff_path.sv
`timescale 1ns / 1ps

module dfiir_ff_path #(
	parameter int FF_TAPS = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  dfiir_pkg::cfg_t    cfg,
	dfiir_in_if.sink           req,
	output logic               ffo_valid,
	input  logic               ffo_ready,
	output dfiir_pkg::ff_sum_t ffo
);
	import dfiir_pkg::*;

	sample_t hist_q [FF_TAPS];
	logic    valid_s1, clr_s1;
	prod_t   prod_s2 [FF_TAPS];
	logic    valid_s2, clr_s2;
	acc_t    sum_s3;
	logic    valid_s3, clr_s3;
	acc_t    sum_d;
	logic    adv_s1, adv_s2, adv_s3, accept;

	// Each stage moves on when the one after it is empty or moving too.
	assign adv_s3    = valid_s3 && ffo_ready;
	assign adv_s2    = valid_s2 && (!valid_s3 || adv_s3);
	assign adv_s1    = valid_s1 && (!valid_s2 || adv_s2);
	assign req.ready = !valid_s1 || adv_s1;
	assign accept    = req.valid && req.ready;

	// Accepts shift the input history, clears zero it; it is stage 1.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			clr_s1   <= 1'b0;
			for (int i = 0; i < FF_TAPS; i++) hist_q[i] <= '0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
			clr_s1   <= req.req_type;
			if (req.req_type == REQ_CLEAR) begin
				for (int i = 0; i < FF_TAPS; i++) hist_q[i] <= '0;
			end else begin
				for (int i = FF_TAPS - 1; i > 0; i--) hist_q[i] <= hist_q[i-1];
				hist_q[0] <= req.sample_in;
			end
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= 1'b1;
		end else if (adv_s2) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			clr_s2 <= clr_s1;
			for (int i = 0; i < FF_TAPS; i++) begin
				if (i < int'(cfg.ff_taps_used))
					prod_s2[i] <= $signed(hist_q[i]) * $signed(cfg.ff_gain[i]);
				else
					prod_s2[i] <= '0;
			end
		end
	end

	always_comb begin
		sum_d = '0;
		for (int i = 0; i < FF_TAPS; i++) sum_d = sum_d + acc_t'(prod_s2[i]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv_s2) begin
			valid_s3 <= 1'b1;
		end else if (adv_s3) begin
			valid_s3 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			clr_s3 <= clr_s2;
			sum_s3 <= sum_d;
		end
	end

	assign ffo_valid = valid_s3;
	assign ffo.clr   = clr_s3;
	assign ffo.sum   = sum_s3;
endmodule

>>> rtl/dfiir_fb_stage.sv
`timescale 1ns / 1ps

module dfiir_fb_stage #(
	parameter int FB_TAPS = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  dfiir_pkg::cfg_t    cfg,
	input  logic               ffi_valid,
	output logic               ffi_ready,
	input  dfiir_pkg::ff_sum_t ffi,
	dfiir_out_if.source        res
);
	import dfiir_pkg::*;

	acc_t            fb_sum, acc, rnd;
	logic [Q_W-1:0]  q;
	logic [Q_W-SAMPLE_W:0] q_hi;
	logic            fits;
	sample_t         y;
	logic            take;
	logic            res_valid_q;
	sample_t         res_data_q;
	logic            res_sat_q;

	assign ffi_ready = !res_valid_q || res.ready;
	assign take      = ffi_valid && ffi_ready;

	generate
		if (FB_TAPS > 0) begin : g_fb
			sample_t yhist_q [FB_TAPS];
			prod_t   fb_prod [FB_TAPS];

			always_comb begin
				fb_sum = '0;
				for (int i = 0; i < FB_TAPS; i++) begin
					fb_prod[i] = $signed(yhist_q[i]) * $signed(cfg.fb_gain[i]);
					if (i < int'(cfg.fb_taps_used)) fb_sum = fb_sum + acc_t'(fb_prod[i]);
				end
			end

			// Clamped outputs enter the history; a clear zeroes it.
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					for (int i = 0; i < FB_TAPS; i++) yhist_q[i] <= '0;
				end else if (take) begin
					if (ffi.clr) begin
						for (int i = 0; i < FB_TAPS; i++) yhist_q[i] <= '0;
					end else begin
						for (int i = FB_TAPS - 1; i > 0; i--) yhist_q[i] <= yhist_q[i-1];
						yhist_q[0] <= y;
					end
				end
			end
		end else begin : g_nofb
			assign fb_sum = '0;
		end
	endgenerate

	// Round half up: add one half, then floor by dropping the fraction bits.
	assign acc  = ffi.sum - fb_sum;
	assign rnd  = acc + ROUND_HALF;
	assign q    = rnd[ACC_W-1:FRAC_SHIFT];
	assign q_hi = q[Q_W-1:SAMPLE_W-1];
	assign fits = (&q_hi) || !(|q_hi);
	assign y    = fits ? sample_t'(q[SAMPLE_W-1:0]) : (q[Q_W-1] ? SAMPLE_MIN : SAMPLE_MAX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (take && !ffi.clr) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && !ffi.clr) begin
			res_data_q <= y;
			res_sat_q  <= !fits;
		end
	end

	assign res.valid        = res_valid_q;
	assign res.filtered_out = res_data_q;
	assign res.saturated    = res_sat_q;
endmodule

>>> rtl/direct_form_iir_filter.sv
`timescale 1ns / 1ps

// Direct-form-I IIR filter, Q12.12 samples and Q8.16 gains. A filter request
// (req_type 0) shifts sample_in into the input history and returns one result:
// the sum of feed-forward gain times input history over the taps in use, minus
// feedback gain times output history over the feedback taps in use, rounded
// half up to Q12.12 and clamped to 24 bits (saturated flags the clamp). A clear
// request (req_type 1) zeroes both histories and returns nothing. The block
// takes one request every cycle while the result side does not stall; the
// input history, the products, the feed-forward sum and the result are each
// held in a register of their own. The feedback multiply, subtract, round
// and clamp are combinational, since each output feeds the next sample, and
// that path sets the clock. Write the configuration registers only while no
// request is in flight.
module direct_form_iir_filter #(
	parameter int FF_TAPS = 4,
	parameter int FB_TAPS = 2
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [dfiir_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [dfiir_pkg::CFG_DATA_W-1:0]  cfg_data,
	dfiir_in_if.sink                          sample_ch,
	dfiir_out_if.source                       result_ch
);
	import dfiir_pkg::*;

	cfg_t    cfg;
	logic    ff_valid, ff_ready;
	ff_sum_t ff_sum;

	// Gain and tap-count registers.
	dfiir_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	// Input history, feed-forward products and their sum.
	dfiir_ff_path #(
		.FF_TAPS (FF_TAPS)
	) u_ff (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.req       (sample_ch),
		.ffo_valid (ff_valid),
		.ffo_ready (ff_ready),
		.ffo       (ff_sum)
	);

	// Feedback, rounding, clamp, output history and the result register.
	dfiir_fb_stage #(
		.FB_TAPS (FB_TAPS)
	) u_fb (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.ffi_valid (ff_valid),
		.ffi_ready (ff_ready),
		.ffi       (ff_sum),
		.res       (result_ch)
	);
endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
	import dfiir_pkg::*;

	// Clears give no result to wait for, so settle() holds off past the pipeline
	// depth before the registers are touched.
	localparam int LATENCY         = 3;
	localparam int SETTLE_CYCLES   = LATENCY + 4;
	// Worst quiet stretch: the longest sender gap, the longest receiver stall,
	// the pipeline and a full register reload. Take it ten times over.
	localparam int WATCHDOG_LIMIT  = 1000;
	localparam int NUM_PHASES      = 10;
	localparam int ITEMS_PER_PHASE = 65;
	localparam int MAX_REPORTS     = 100;

	localparam gain_t GAIN_MAX = {1'b0, {(GAIN_W-1){1'b1}}};
	localparam gain_t GAIN_MIN = {1'b1, {(GAIN_W-1){1'b0}}};

	typedef struct {
		sample_t value;
		logic    sat;
	} filter_result_t;

	// One row of the directed table: either a register write or a request,
	// optionally with the result typed in by hand.
	typedef struct {
		logic                  is_cfg;
		cfg_idx_e              reg_idx;
		logic [CFG_DATA_W-1:0] data;
		logic                  req;
		sample_t               sample;
		logic                  has_lit;
		sample_t               lit_value;
		logic                  lit_sat;
	} stim_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;

	dfiir_in_if  sample_ch();
	dfiir_out_if result_ch();

	direct_form_iir_filter #(
		.FF_TAPS(NUM_FF_GAIN),
		.FB_TAPS(NUM_FB_GAIN)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data),
		.sample_ch (sample_ch),
		.result_ch (result_ch)
	);

	// Predictor copy of the registers and of both histories (newest first).
	gain_t                ff_gain [NUM_FF_GAIN];
	gain_t                fb_gain [NUM_FB_GAIN];
	logic [FF_TAPS_W-1:0] ff_taps;
	logic [FB_TAPS_W-1:0] fb_taps;
	sample_t              in_hist [NUM_FF_GAIN];
	sample_t              out_hist [NUM_FB_GAIN];

	filter_result_t pending_outputs[$];
	int             err_count = 0;
	int             idle_cycles = 0;
	int             sink_stall = 0;
	logic           no_idle = 1'b0;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic void clear_histories();
		foreach (in_hist[i]) in_hist[i] = '0;
		foreach (out_hist[i]) out_hist[i] = '0;
	endfunction

	// Advance the predictor by one filter request and return its output.
	function automatic filter_result_t filter_sample(sample_t x);
		filter_result_t res;
		longint         acc;
		longint         q;
		int             nff;
		int             nfb;

		// Histories always shift at full depth, whatever the taps in use.
		for (int i = NUM_FF_GAIN - 1; i > 0; i--) in_hist[i] = in_hist[i-1];
		in_hist[0] = x;

		// Tap counts above the built depth clamp to it.
		nff = (ff_taps > NUM_FF_GAIN) ? NUM_FF_GAIN : int'(ff_taps);
		nfb = (fb_taps > NUM_FB_GAIN) ? NUM_FB_GAIN : int'(fb_taps);

		acc = 0;
		for (int i = 0; i < nff; i++) acc += longint'(in_hist[i]) * longint'(ff_gain[i]);
		for (int i = 0; i < nfb; i++) acc -= longint'(out_hist[i]) * longint'(fb_gain[i]);

		// Round half up to Q12.12: add the half, then floor-shift.
		q = (acc + longint'(ROUND_HALF)) >>> FRAC_SHIFT;

		res.sat = 1'b1;
		if (q > longint'(SAMPLE_MAX)) begin
			res.value = SAMPLE_MAX;
		end else if (q < longint'(SAMPLE_MIN)) begin
			res.value = SAMPLE_MIN;
		end else begin
			res.value = sample_t'(q);
			res.sat   = 1'b0;
		end

		// The clamped value is what the feedback path sees next time.
		for (int i = NUM_FB_GAIN - 1; i > 0; i--) out_hist[i] = out_hist[i-1];
		out_hist[0] = res.value;
		return res;
	endfunction

	task automatic report_mismatch(string what);
		err_count++;
		if (err_count <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, what);
	endtask

	// Mostly back-to-back, sometimes a short gap, now and then a long one.
	function automatic int pick_gap();
		int r;
		if (no_idle) return 0;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic sample_t pick_sample();
		int r;
		r = $urandom_range(0, 99);
		if (r < 4) return SAMPLE_MAX;
		if (r < 8) return SAMPLE_MIN;
		if (r < 10) return '0;
		if (r < 12) return sample_t'(-1);
		if (r < 55) return sample_t'($urandom);
		// Small values keep the filter out of saturation most of the time.
		return sample_t'(int'($urandom_range(0, 65535)) - 32768);
	endfunction

	// Phase 0 loads every gain at its top, phase 1 at its bottom; later phases
	// mix extremes, full-range values and gains near unity; in that last range
	// feedback gains stay below one half, so the loop does not just saturate.
	function automatic gain_t pick_gain(int phase, logic feedback);
		int r;
		int lim;
		if (phase == 0) return GAIN_MAX;
		if (phase == 1) return GAIN_MIN;
		r = $urandom_range(0, 9);
		if (r == 0) return GAIN_MAX;
		if (r == 1) return GAIN_MIN;
		if (r == 2) return '0;
		if (r < 5) return gain_t'($urandom);
		lim = feedback ? 29491 : int'(GAIN_ONE);
		return gain_t'(int'($urandom_range(0, 2 * lim)) - lim);
	endfunction

	function automatic stim_row_t cfg_row(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
		stim_row_t row;
		row         = '{reg_idx: CFG_FF_GAIN_0, default: '0};
		row.is_cfg  = 1'b1;
		row.reg_idx = idx;
		row.data    = data;
		return row;
	endfunction

	function automatic stim_row_t req_row(logic req, sample_t s);
		stim_row_t row;
		row         = '{reg_idx: CFG_FF_GAIN_0, default: '0};
		row.req     = req;
		row.sample  = s;
		return row;
	endfunction

	function automatic stim_row_t lit_row(sample_t s, sample_t value, logic sat);
		stim_row_t row;
		row           = req_row(REQ_FILTER, s);
		row.has_lit   = 1'b1;
		row.lit_value = value;
		row.lit_sat   = sat;
		return row;
	endfunction

	// Drive one register write; the caller drops cfg_we after the last one.
	task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			CFG_FF_GAIN_0:    ff_gain[0] = data;
			CFG_FF_GAIN_1:    ff_gain[1] = data;
			CFG_FF_GAIN_2:    ff_gain[2] = data;
			CFG_FF_GAIN_3:    ff_gain[3] = data;
			CFG_FB_GAIN_0:    fb_gain[0] = data;
			CFG_FB_GAIN_1:    fb_gain[1] = data;
			CFG_FF_TAPS_USED: ff_taps = data[FF_TAPS_W-1:0];
			CFG_FB_TAPS_USED: fb_taps = data[FB_TAPS_W-1:0];
			default: ;
		endcase
	endtask

	// Wait for every expected result, then let a trailing clear drain.
	task automatic settle();
		while (pending_outputs.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Offer one request, wait for its transfer and record what must come out.
	// Valid is dropped only when a gap follows, so back-to-back requests keep
	// it high without a second assignment in the same step.
	task automatic send_request(logic req, sample_t s, int gap, logic has_lit = 1'b0,
			sample_t lit_value = '0, logic lit_sat = 1'b0);
		filter_result_t predicted;
		sample_ch.valid     <= 1'b1;
		sample_ch.req_type  <= req;
		sample_ch.sample_in <= s;
		do @(posedge clk); while (sample_ch.ready !== 1'b1);
		if (req == REQ_CLEAR) begin
			// Clear keeps the registers and returns nothing.
			clear_histories();
		end else begin
			predicted = filter_sample(s);
			if (has_lit) begin
				predicted.value = lit_value;
				predicted.sat   = lit_sat;
			end
			pending_outputs.push_back(predicted);
		end
		if (gap > 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Result side: check each transfer against the oldest expectation, then
	// pick the next ready value. Stalls follow the same gap profile as the
	// sender, and vanish in the phases that run without idling.
	always @(posedge clk) begin : result_side
		filter_result_t want;
		if (arst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
			if (pending_outputs.size() == 0) begin
				report_mismatch($sformatf("unexpected result %h sat %b",
					result_ch.filtered_out, result_ch.saturated));
			end else begin
				want = pending_outputs.pop_front();
				if (result_ch.filtered_out !== want.value)
					report_mismatch($sformatf("filtered_out %h, want %h",
						result_ch.filtered_out, want.value));
				if (result_ch.saturated !== want.sat)
					report_mismatch($sformatf("saturated %b, want %b",
						result_ch.saturated, want.sat));
			end
		end
		if (no_idle) begin
			result_ch.ready <= 1'b1;
		end else if (sink_stall > 0) begin
			sink_stall--;
			result_ch.ready <= 1'b0;
		end else begin
			sink_stall = pick_gap();
			result_ch.ready <= (sink_stall == 0);
		end
	end

	// Watchdog: any transfer on either channel restarts the count.
	always @(posedge clk) begin
		if ((sample_ch.valid === 1'b1 && sample_ch.ready === 1'b1) ||
				(result_ch.valid === 1'b1 && result_ch.ready === 1'b1)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin : stimulus
		stim_row_t             directed[$];
		logic                  writing;
		logic                  req;
		logic [CFG_DATA_W-1:0] taps_word;
		int                    gap;

		// Hold every input at a known value from time zero.
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_idx             = CFG_FF_GAIN_0;
		cfg_data            = '0;
		sample_ch.valid     = 1'b0;
		sample_ch.req_type  = REQ_FILTER;
		sample_ch.sample_in = '0;
		result_ch.ready     = 1'b0;

		// Predictor state after reset: unity pass-through, one tap, no feedback.
		ff_gain[0] = GAIN_ONE;
		for (int i = 1; i < NUM_FF_GAIN; i++) ff_gain[i] = '0;
		foreach (fb_gain[i]) fb_gain[i] = '0;
		ff_taps = FF_TAPS_W'(1);
		fb_taps = '0;
		clear_histories();

		// Pass-through after reset: the output equals the input.
		directed.push_back(lit_row('0, '0, 1'b0));
		directed.push_back(lit_row(SAMPLE_MAX, SAMPLE_MAX, 1'b0));
		directed.push_back(lit_row(SAMPLE_MIN, SAMPLE_MIN, 1'b0));
		directed.push_back(lit_row(sample_t'(-1), sample_t'(-1), 1'b0));
		directed.push_back(req_row(REQ_CLEAR, sample_t'(24'h5A5A5A)));
		// Largest gain: both rails clamp.
		directed.push_back(cfg_row(CFG_FF_GAIN_0, GAIN_MAX));
		directed.push_back(lit_row(SAMPLE_MAX, SAMPLE_MAX, 1'b1));
		directed.push_back(lit_row(SAMPLE_MIN, SAMPLE_MIN, 1'b1));
		directed.push_back(lit_row('0, '0, 1'b0));
		// Most negative gain flips the sign before clamping.
		directed.push_back(cfg_row(CFG_FF_GAIN_0, GAIN_MIN));
		directed.push_back(lit_row(SAMPLE_MIN, SAMPLE_MAX, 1'b1));
		directed.push_back(lit_row(SAMPLE_MAX, SAMPLE_MIN, 1'b1));
		// Zero feed-forward taps, with junk above the count field.
		directed.push_back(cfg_row(CFG_FF_TAPS_USED, 24'hFFFFF8));
		directed.push_back(lit_row(sample_t'(12345), '0, 1'b0));
		// Too many taps clamps to four; mixed-sign gains.
		directed.push_back(cfg_row(CFG_FF_TAPS_USED, 24'h000007));
		directed.push_back(cfg_row(CFG_FF_GAIN_0, GAIN_ONE));
		directed.push_back(cfg_row(CFG_FF_GAIN_1, 24'h00C000));
		directed.push_back(cfg_row(CFG_FF_GAIN_2, 24'hFF0000));
		directed.push_back(cfg_row(CFG_FF_GAIN_3, 24'h008000));
		directed.push_back(req_row(REQ_FILTER, sample_t'(24'h001000)));
		directed.push_back(req_row(REQ_FILTER, sample_t'(24'h123456)));
		directed.push_back(req_row(REQ_FILTER, SAMPLE_MIN));
		// Feedback on, with the count above two clamping to two.
		directed.push_back(cfg_row(CFG_FB_GAIN_0, 24'h00C000));
		directed.push_back(cfg_row(CFG_FB_GAIN_1, 24'hFFE000));
		directed.push_back(cfg_row(CFG_FB_TAPS_USED, 24'h000003));
		directed.push_back(req_row(REQ_FILTER, sample_t'(24'h000800)));
		directed.push_back(req_row(REQ_FILTER, sample_t'(24'hFFF000)));
		directed.push_back(req_row(REQ_FILTER, sample_t'(24'h7FF000)));
		// Clear mid-stream: histories restart, gains stay.
		directed.push_back(req_row(REQ_CLEAR, sample_t'(24'hA5A5A5)));
		directed.push_back(req_row(REQ_FILTER, sample_t'(24'h000800)));
		directed.push_back(cfg_row(CFG_FB_TAPS_USED, 24'h000001));
		directed.push_back(req_row(REQ_FILTER, sample_t'(24'h002000)));
		// Half gain on odd inputs: ties round up on both signs.
		directed.push_back(cfg_row(CFG_FF_TAPS_USED, 24'h000001));
		directed.push_back(cfg_row(CFG_FB_TAPS_USED, 24'h000000));
		directed.push_back(cfg_row(CFG_FF_GAIN_0, 24'h008000));
		directed.push_back(lit_row(sample_t'(3), sample_t'(2), 1'b0));
		directed.push_back(lit_row(sample_t'(-3), sample_t'(-1), 1'b0));

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Walk the table. Register writes wait for the pipe to empty; the request
		// before a write or at the end always leaves a gap so valid is low.
		writing = 1'b0;
		foreach (directed[k]) begin
			if (directed[k].is_cfg) begin
				if (!writing) settle();
				write_reg(directed[k].reg_idx, directed[k].data);
				writing = 1'b1;
			end else begin
				if (writing) begin
					cfg_we  <= 1'b0;
					writing = 1'b0;
				end
				gap = pick_gap();
				if (k == directed.size() - 1 || directed[k+1].is_cfg) gap = (gap < 1) ? 1 : gap;
				send_request(directed[k].req, directed[k].sample, gap, directed[k].has_lit,
					directed[k].lit_value, directed[k].lit_sat);
			end
		end

		// Random phases: reload every register while idle, then stream requests.
		// Every fourth phase runs flat out on both sides.
		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			settle();
			no_idle = (phase % 4 == 3);
			write_reg(CFG_FF_GAIN_0, pick_gain(phase, 1'b0));
			write_reg(CFG_FF_GAIN_1, pick_gain(phase, 1'b0));
			write_reg(CFG_FF_GAIN_2, pick_gain(phase, 1'b0));
			write_reg(CFG_FF_GAIN_3, pick_gain(phase, 1'b0));
			write_reg(CFG_FB_GAIN_0, pick_gain(phase, 1'b1));
			write_reg(CFG_FB_GAIN_1, pick_gain(phase, 1'b1));
			// Tap counts carry random junk in the unused upper bits.
			taps_word = CFG_DATA_W'($urandom);
			taps_word[FF_TAPS_W-1:0] = (phase < 2) ? FF_TAPS_W'(NUM_FF_GAIN) :
				FF_TAPS_W'($urandom_range(0, 7));
			write_reg(CFG_FF_TAPS_USED, taps_word);
			taps_word = CFG_DATA_W'($urandom);
			taps_word[FB_TAPS_W-1:0] = (phase < 2) ? FB_TAPS_W'(NUM_FB_GAIN) :
				FB_TAPS_W'($urandom_range(0, 3));
			write_reg(CFG_FB_TAPS_USED, taps_word);
			cfg_we <= 1'b0;

			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				gap = pick_gap();
				if (n == ITEMS_PER_PHASE - 1) gap = (gap < 1) ? 1 : gap;
				req = ($urandom_range(0, 99) < 5) ? REQ_CLEAR : REQ_FILTER;
				send_request(req, (req == REQ_CLEAR) ? sample_t'($urandom) : pick_sample(), gap);
			end
		end

		no_idle = 1'b0;
		settle();
		if (err_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
